// ===== design/swpm_pkg.sv =====
// Shared types, codes and reset constants of the spare worker pool manager.
package swpm_pkg;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_ARRIVE      = 2'd0,
    ACT_CREATED     = 2'd1,
    ACT_FINISHED    = 2'd2,
    ACT_CONSOLIDATE = 2'd3
  } act_t;

  // Result command codes
  typedef enum logic [2:0] {
    CMD_STATUS   = 3'd0,
    CMD_DISPATCH = 3'd1,
    CMD_CREATE   = 3'd2,
    CMD_KILL     = 3'd3,
    CMD_DROP     = 3'd4
  } cmd_t;

  // Event classes handed from front to back
  typedef enum logic [1:0] {
    EV_ARRIVE = 2'd0,
    EV_FREE   = 2'd1,
    EV_CONS   = 2'd2
  } ev_kind_t;

  // Configuration register indexes
  localparam logic [1:0] REG_POOL_LIMIT    = 2'd0;
  localparam logic [1:0] REG_SPARE_MINIMUM = 2'd1;
  localparam logic [1:0] REG_SPARE_MAXIMUM = 2'd2;
  localparam logic [1:0] REG_QUEUE_LIMIT   = 2'd3;

  localparam logic [5:0] POOL_LIMIT_RST    = 6'd32;
  localparam logic [5:0] SPARE_MINIMUM_RST = 6'd5;
  localparam logic [5:0] SPARE_MAXIMUM_RST = 6'd10;
  localparam logic [5:0] QUEUE_LIMIT_RST   = 6'd63;

  typedef struct packed {
    act_t        action;
    logic [31:0] page_bytes;
    logic [31:0] work_cycles;
  } in_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] out_page_bytes;
    logic [31:0] out_work_cycles;
    logic [5:0]  idle_count;
    logic [5:0]  busy_count;
    logic [5:0]  pending_count;
    logic [6:0]  waiting_count;
    logic        underflow;
    logic        last;
  } out_t;

  // Classified event
  typedef struct packed {
    ev_kind_t    kind;
    logic        dec_pending;  // free event came from a worker creation
    logic [31:0] page_bytes;
    logic [31:0] work_cycles;
  } ev_t;

  // Configuration set
  typedef struct packed {
    logic [5:0] pool_limit;
    logic [5:0] spare_minimum;
    logic [5:0] spare_maximum;
    logic [5:0] queue_limit;
  } cfg_t;

endpackage

// ===== design/swpm_ram.sv =====
// Generic single write port RAM with registered read.
module swpm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/swpm_front.sv =====
// Front end: accepts input items and classifies them into pool events.
module swpm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  swpm_pkg::in_t in_data,
  output logic          ev_valid,
  input  logic          ev_ready,
  output swpm_pkg::ev_t ev_data
);
  import swpm_pkg::*;

  logic valid_r;
  ev_t  ev_r;
  ev_t  ev_nxt;

  // Classify the action
  always_comb begin
    ev_nxt.page_bytes  = in_data.page_bytes;
    ev_nxt.work_cycles = in_data.work_cycles;
    ev_nxt.dec_pending = 1'b0;
    case (in_data.action)
      ACT_ARRIVE: begin
        ev_nxt.kind = EV_ARRIVE;
      end
      ACT_CREATED: begin
        ev_nxt.kind        = EV_FREE;
        ev_nxt.dec_pending = 1'b1;
      end
      ACT_FINISHED: begin
        ev_nxt.kind = EV_FREE;
      end
      default: begin
        ev_nxt.kind = EV_CONS;
      end
    endcase
  end

  assign in_ready = !valid_r || ev_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      ev_r <= ev_nxt;
    end
  end

  assign ev_valid = valid_r;
  assign ev_data  = ev_r;

endmodule

// ===== design/swpm_evq.sv =====
// Two-entry event queue between front and back.
module swpm_evq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  swpm_pkg::ev_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output swpm_pkg::ev_t pop_data
);
  import swpm_pkg::*;

  localparam logic [1:0] FULL_CNT = 2'd2;

  ev_t        entry_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
    if (push) begin
      entry_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== design/swpm_back.sv =====
// Back end: sequencer that owns the worker counters and waiting queue.
module swpm_back #(
  parameter int QUEUE_DEPTH = 64,
  parameter int POOL_MAX    = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  swpm_pkg::cfg_t cfg,
  input  logic           ev_valid,
  output logic           ev_ready,
  input  swpm_pkg::ev_t  ev_data,
  output logic           out_valid,
  input  logic           out_ready,
  output swpm_pkg::out_t out_data
);
  import swpm_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [5:0]        POOL_MAX_C = 6'(POOL_MAX);
  localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STATUS,
    S_READ,
    S_DISP,
    S_CREATE,
    S_KILL
  } state_t;

  state_t            state_r, state_nxt;
  logic [5:0]        idle_r, idle_nxt;
  logic [5:0]        busy_r, busy_nxt;
  logic [5:0]        pend_r, pend_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              under_r, under_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic        emit_ok;
  logic        emit;
  cmd_t        emit_cmd;
  logic [31:0] emit_page;
  logic [31:0] emit_cyc;
  logic        emit_last;
  logic        ram_we;
  logic [63:0] ram_rdata;
  logic [5:0]  lim;
  logic [7:0]  sum_pi;
  logic [7:0]  sum_all;
  logic        create_ok;
  logic        kill_ok;
  logic        drop;

  function automatic logic [5:0] sat_inc(input logic [5:0] v);
    return (v >= POOL_MAX_C) ? POOL_MAX_C : v + 6'd1;
  endfunction

  // Waiting request store: page in the low half, cycles in the high half
  swpm_ram #(
    .WIDTH (64),
    .DEPTH (QUEUE_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata ({ev_data.work_cycles, ev_data.page_bytes}),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Pool conditions from the current counters
  assign lim       = (cfg.pool_limit > POOL_MAX_C) ? POOL_MAX_C : cfg.pool_limit;
  assign sum_pi    = {2'b00, pend_r} + {2'b00, idle_r};
  assign sum_all   = sum_pi + {2'b00, busy_r};
  assign create_ok = (sum_pi < {2'b00, cfg.spare_minimum}) && (sum_all < {2'b00, lim});
  assign kill_ok   = (idle_r > cfg.spare_maximum);
  assign drop      = (32'(fill_r) > 32'(cfg.queue_limit)) || (fill_r >= FILL_FULL);
  assign emit_ok   = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    idle_nxt  = idle_r;
    busy_nxt  = busy_r;
    pend_nxt  = pend_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_nxt  = fill_r;
    under_nxt = under_r;
    emit      = 1'b0;
    emit_cmd  = CMD_STATUS;
    emit_page = 32'd0;
    emit_cyc  = 32'd0;
    emit_last = 1'b0;
    ram_we    = 1'b0;
    ev_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (ev_valid && emit_ok) begin
          ev_ready  = 1'b1;
          under_nxt = 1'b0;
          case (ev_data.kind)
            EV_ARRIVE: begin
              if (drop) begin
                emit      = 1'b1;
                emit_cmd  = CMD_DROP;
                emit_last = 1'b1;
              end else if (idle_r != 6'd0) begin
                idle_nxt  = idle_r - 6'd1;
                busy_nxt  = sat_inc(busy_r);
                emit      = 1'b1;
                emit_cmd  = CMD_DISPATCH;
                emit_page = ev_data.page_bytes;
                emit_cyc  = ev_data.work_cycles;
                state_nxt = S_STATUS;
              end else begin
                ram_we    = 1'b1;
                tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
                fill_nxt  = fill_r + FILL_W'(1);
                state_nxt = S_CREATE;
              end
            end
            EV_FREE: begin
              if (ev_data.dec_pending) begin
                if (pend_r == 6'd0) begin
                  under_nxt = 1'b1;
                end else begin
                  pend_nxt = pend_r - 6'd1;
                end
              end else begin
                if (busy_r == 6'd0) begin
                  under_nxt = 1'b1;
                end else begin
                  busy_nxt = busy_r - 6'd1;
                end
              end
              idle_nxt  = sat_inc(idle_r);
              state_nxt = (fill_r != '0) ? S_READ : S_CREATE;
            end
            default: begin
              state_nxt = S_CREATE;
            end
          endcase
        end
      end
      S_READ: begin
        // head entry is on the RAM output next cycle
        state_nxt = S_DISP;
      end
      S_DISP: begin
        if (emit_ok) begin
          head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
          fill_nxt  = fill_r - FILL_W'(1);
          idle_nxt  = idle_r - 6'd1;
          busy_nxt  = sat_inc(busy_r);
          emit      = 1'b1;
          emit_cmd  = CMD_DISPATCH;
          emit_page = ram_rdata[31:0];
          emit_cyc  = ram_rdata[63:32];
          state_nxt = S_CREATE;
        end
      end
      S_CREATE: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (create_ok) begin
            pend_nxt = pend_r + 6'd1;
            emit_cmd = CMD_CREATE;
          end else if (kill_ok) begin
            idle_nxt  = idle_r - 6'd1;
            emit_cmd  = CMD_KILL;
            state_nxt = S_KILL;
          end else begin
            emit_last = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_KILL: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (kill_ok) begin
            idle_nxt = idle_r - 6'd1;
            emit_cmd = CMD_KILL;
          end else begin
            emit_last = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_STATUS: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_nxt.command         = emit_cmd;
      out_nxt.out_page_bytes  = emit_page;
      out_nxt.out_work_cycles = emit_cyc;
      out_nxt.idle_count      = idle_nxt;
      out_nxt.busy_count      = busy_nxt;
      out_nxt.pending_count   = pend_nxt;
      out_nxt.waiting_count   = 7'(fill_nxt);
      out_nxt.underflow       = under_nxt;
      out_nxt.last            = emit_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idle_r      <= '0;
      busy_r      <= '0;
      pend_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      under_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idle_r      <= idle_nxt;
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      under_r     <= under_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/spare_worker_pool_manager.sv =====
// Top level of the spare worker pool manager: config registers, front, queue, back.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_data   (swpm_pkg::in_t)
//   out_     output     out_valid / out_ready out_data  (swpm_pkg::out_t)
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// An item passes through the front register and then the event queue.
// The back sequencer then starts the event, reads and dispatches a queued
// request when one is waiting, issues each create or kill command in turn and
// ends with the final status, or with a drop result for a dropped arrival.
// Reset is synchronous, active low; the waiting store is not cleared.
// A stalled result channel holds the sequencer; the front keeps taking items
// until the event queue fills.
module spare_worker_pool_manager #(
  parameter int QUEUE_DEPTH = 64,
  parameter int POOL_MAX    = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  swpm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output swpm_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [5:0]     cfg_wdata
);
  import swpm_pkg::*;

  cfg_t cfg_r;
  logic fq_valid;
  logic fq_ready;
  ev_t  fq_data;
  logic qb_valid;
  logic qb_ready;
  ev_t  qb_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pool_limit    <= POOL_LIMIT_RST;
      cfg_r.spare_minimum <= SPARE_MINIMUM_RST;
      cfg_r.spare_maximum <= SPARE_MAXIMUM_RST;
      cfg_r.queue_limit   <= QUEUE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POOL_LIMIT:    cfg_r.pool_limit    <= cfg_wdata;
        REG_SPARE_MINIMUM: cfg_r.spare_minimum <= cfg_wdata;
        REG_SPARE_MAXIMUM: cfg_r.spare_maximum <= cfg_wdata;
        REG_QUEUE_LIMIT:   cfg_r.queue_limit   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  swpm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .ev_valid (fq_valid),
    .ev_ready (fq_ready),
    .ev_data  (fq_data)
  );

  swpm_evq u_evq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  swpm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .POOL_MAX    (POOL_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ev_valid  (qb_valid),
    .ev_ready  (qb_ready),
    .ev_data   (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Drop results always close their item
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.command == CMD_DROP) |-> out_data.last)
    else $error("drop result without last");

  // Dispatch, create and kill results never close an item
  a_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.command == CMD_DISPATCH) || (out_data.command == CMD_CREATE) ||
    (out_data.command == CMD_KILL)) |-> !out_data.last)
    else $error("intermediate result marked last");

  // Worker counters stay within the pool size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.idle_count) <= POOL_MAX) &&
    (32'(out_data.busy_count) <= POOL_MAX) && (32'(out_data.pending_count) <= POOL_MAX))
    else $error("worker count above pool size");

  // A kill result that directly follows an accepted kill result shows an idle count one lower
  a_kill_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_data.command == CMD_KILL) ##1
    out_valid && (out_data.command == CMD_KILL) |->
    (out_data.idle_count == $past(out_data.idle_count) - 6'd1))
    else $error("kill did not lower idle count by one");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench of the spare worker pool manager: directed pool scenarios, random phases, then a full waiting store.
module testbench;
  import swpm_pkg::*;

  localparam int QUEUE_CAP     = 64;
  localparam int POOL_CAP      = 32;
  localparam int REG_MAX       = 63;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASES        = 2;
  localparam int PHASE_EVENTS  = 10;
  localparam int OWED_CAP      = 1024;

  // receiver behavior while it holds a result back
  typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = REG_POOL_LIMIT;
  logic [5:0] cfg_wdata = '0;

  // transfer flags for the coming edge, sampled mid-cycle
  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;

  int err_count  = 0;
  int n_events   = 0;
  int n_results  = 0;
  int n_dispatch = 0;
  int n_create   = 0;
  int n_kill     = 0;
  int n_drop     = 0;
  int n_under    = 0;
  int burst_left = 0;

  // predicted pool state and register copies
  int          cfg_pool_limit = int'(POOL_LIMIT_RST);
  int          cfg_spare_min  = int'(SPARE_MINIMUM_RST);
  int          cfg_spare_max  = int'(SPARE_MAXIMUM_RST);
  int          cfg_queue_lim  = int'(QUEUE_LIMIT_RST);
  int          pm_idle        = 0;
  int          pm_busy        = 0;
  int          pm_pending     = 0;
  logic        pm_under       = 1'b0;

  // waiting requests and expected results, kept as rings
  logic [63:0] pm_wait_ring [QUEUE_CAP];
  int          pm_wait_head  = 0;
  int          pm_wait_count = 0;
  out_t        owed_ring [OWED_CAP];
  int          owed_head     = 0;
  int          owed_count    = 0;

  rx_mode_t   rx_mode  = RX_STREAM;
  logic [7:0] rx_bits  = 8'h01;
  int         rx_span  = 0;

  always #10 clk = ~clk;

  spare_worker_pool_manager #(
    .QUEUE_DEPTH(QUEUE_CAP),
    .POOL_MAX   (POOL_CAP)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------- ring helpers ----------------

  function automatic void wait_add(logic [63:0] e);
    pm_wait_ring[(pm_wait_head + pm_wait_count) % QUEUE_CAP] = e;
    pm_wait_count++;
  endfunction

  function automatic logic [63:0] wait_take();
    logic [63:0] e;
    e = pm_wait_ring[pm_wait_head];
    pm_wait_head = (pm_wait_head + 1) % QUEUE_CAP;
    pm_wait_count--;
    return e;
  endfunction

  function automatic void owed_add(out_t r);
    owed_ring[(owed_head + owed_count) % OWED_CAP] = r;
    owed_count++;
  endfunction

  function automatic out_t owed_take();
    out_t r;
    r = owed_ring[owed_head];
    owed_head = (owed_head + 1) % OWED_CAP;
    owed_count--;
    return r;
  endfunction

  // ---------------- pool predictor ----------------

  function automatic int sat_count(int v);
    return (v >= POOL_CAP) ? POOL_CAP : v + 1;
  endfunction

  function automatic void owe_result(cmd_t cmd, logic [31:0] pg, logic [31:0] wc, logic fin);
    out_t r;
    r.command         = cmd;
    r.out_page_bytes  = pg;
    r.out_work_cycles = wc;
    r.idle_count      = 6'(pm_idle);
    r.busy_count      = 6'(pm_busy);
    r.pending_count   = 6'(pm_pending);
    r.waiting_count   = 7'(pm_wait_count);
    r.underflow       = pm_under;
    r.last            = fin;
    owed_add(r);
  endfunction

  // order workers up to the spare minimum, then trim idle ones above the spare maximum
  function automatic void plan_consolidation();
    int lim;
    lim = (cfg_pool_limit > POOL_CAP) ? POOL_CAP : cfg_pool_limit;
    while (pm_pending + pm_idle < cfg_spare_min &&
           pm_pending + pm_idle + pm_busy < lim) begin
      pm_pending++;
      owe_result(CMD_CREATE, '0, '0, 1'b0);
    end
    while (pm_idle > cfg_spare_max) begin
      pm_idle--;
      owe_result(CMD_KILL, '0, '0, 1'b0);
    end
  endfunction

  // a worker became available: hand it the oldest waiting request if any
  function automatic void plan_free_worker();
    logic [63:0] entry;
    pm_idle = sat_count(pm_idle);
    if (pm_wait_count > 0) begin
      entry = wait_take();
      pm_idle--;
      pm_busy = sat_count(pm_busy);
      owe_result(CMD_DISPATCH, entry[31:0], entry[63:32], 1'b0);
    end
    plan_consolidation();
  endfunction

  function automatic void pool_event_outcome(in_t item);
    pm_under = 1'b0;
    case (item.action)
      ACT_ARRIVE: begin
        if (pm_wait_count > cfg_queue_lim || pm_wait_count >= QUEUE_CAP) begin
          owe_result(CMD_DROP, '0, '0, 1'b1);
          return;
        end
        if (pm_idle > 0) begin
          pm_idle--;
          pm_busy = sat_count(pm_busy);
          owe_result(CMD_DISPATCH, item.page_bytes, item.work_cycles, 1'b0);
        end else begin
          wait_add({item.work_cycles, item.page_bytes});
          plan_consolidation();
        end
      end
      ACT_CREATED: begin
        if (pm_pending == 0) pm_under = 1'b1;
        else pm_pending--;
        plan_free_worker();
      end
      ACT_FINISHED: begin
        if (pm_busy == 0) pm_under = 1'b1;
        else pm_busy--;
        plan_free_worker();
      end
      default: plan_consolidation();
    endcase
    owe_result(CMD_STATUS, '0, '0, 1'b1);
  endfunction

  // ---------------- result checking ----------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  task automatic check_result(out_t got);
    out_t want;
    n_results++;
    if (got.underflow) n_under++;
    case (got.command)
      CMD_DISPATCH: n_dispatch++;
      CMD_CREATE:   n_create++;
      CMD_KILL:     n_kill++;
      CMD_DROP:     n_drop++;
      default: ;
    endcase
    if (owed_count == 0) begin
      $display("%0t: unexpected result, expected none actual command %0d",
               $time, got.command);
      err_count++;
      return;
    end
    want = owed_take();
    check_field("command", 32'(want.command), 32'(got.command));
    check_field("out_page_bytes", want.out_page_bytes, got.out_page_bytes);
    check_field("out_work_cycles", want.out_work_cycles, got.out_work_cycles);
    check_field("idle_count", 32'(want.idle_count), 32'(got.idle_count));
    check_field("busy_count", 32'(want.busy_count), 32'(got.busy_count));
    check_field("pending_count", 32'(want.pending_count), 32'(got.pending_count));
    check_field("waiting_count", 32'(want.waiting_count), 32'(got.waiting_count));
    check_field("underflow", 32'(want.underflow), 32'(got.underflow));
    check_field("last", 32'(want.last), 32'(got.last));
  endtask

  // sample handshakes between edges; a transfer happens at the next rising edge
  always @(negedge clk) begin
    in_fire  = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    if (out_fire) check_result(out_data);
  end

  // receiver stalls: streaming, random, or a rotating bit pattern
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_bits = 8'($urandom) | 8'h01;
      rx_span = $urandom_range(16, 64);
    end
    rx_span--;
    rx_bits = {rx_bits[6:0], rx_bits[7]};
    case (rx_mode)
      RX_STREAM: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default:   out_ready <= rx_bits[0];
    endcase
  end

  // ---------------- stimulus helpers ----------------

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic int pick_setting(int lo, int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (r == 2) return int'($urandom_range(0, REG_MAX));
    return int'($urandom_range(lo, hi));
  endfunction

  // one event transfer; bursts of random length separated by random gaps
  task automatic send_event(act_t a, logic [31:0] pg, logic [31:0] wc);
    in_t item;
    int  gap;
    item.action      = a;
    item.page_bytes  = pg;
    item.work_cycles = wc;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_fire) @(posedge clk);
    pool_event_outcome(item);
    n_events++;
  endtask

  // hold the sender until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (owed_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [5:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_POOL_LIMIT:    cfg_pool_limit = int'(val);
      REG_SPARE_MINIMUM: cfg_spare_min  = int'(val);
      REG_SPARE_MAXIMUM: cfg_spare_max  = int'(val);
      default:           cfg_queue_lim  = int'(val);
    endcase
  endtask

  task automatic set_config(int pool, int smin, int smax, int qlim);
    put_reg(REG_POOL_LIMIT, 6'(pool));
    put_reg(REG_SPARE_MINIMUM, 6'(smin));
    put_reg(REG_SPARE_MAXIMUM, 6'(smax));
    put_reg(REG_QUEUE_LIMIT, 6'(qlim));
    cfg_we <= 1'b0;
  endtask

  // ---------------- tests ----------------

  // reset settings: spares ordered, arrivals dispatched to idle workers until none is left, then queued
  task automatic test_reset_behavior();
    send_event(ACT_CONSOLIDATE, rand_word(), rand_word());
    send_event(ACT_CREATED, rand_word(), rand_word());
    send_event(ACT_CREATED, rand_word(), rand_word());
    send_event(ACT_ARRIVE, '0, '0);
    send_event(ACT_ARRIVE, '1, '1);
    send_event(ACT_ARRIVE, rand_word(), rand_word());
    send_event(ACT_FINISHED, rand_word(), rand_word());
  endtask

  // finish with no busy worker, creation with nothing ordered
  task automatic test_underflow();
    wait_drained();
    set_config(POOL_CAP, 0, POOL_CAP, REG_MAX);
    while (pm_busy > 0) send_event(ACT_FINISHED, rand_word(), rand_word());
    send_event(ACT_FINISHED, rand_word(), rand_word());
    while (pm_pending > 0) send_event(ACT_CREATED, rand_word(), rand_word());
    send_event(ACT_CREATED, rand_word(), rand_word());
  endtask

  // drops against small queue limits, then draining in order
  task automatic test_queue_limit();
    wait_drained();
    set_config(POOL_CAP, 0, 0, 2);
    send_event(ACT_CONSOLIDATE, rand_word(), rand_word());
    repeat (4) send_event(ACT_ARRIVE, rand_word(), rand_word());
    wait_drained();
    set_config(POOL_CAP, 0, 0, 0);
    send_event(ACT_ARRIVE, rand_word(), rand_word());
    repeat (3) send_event(ACT_FINISHED, rand_word(), rand_word());
    send_event(ACT_ARRIVE, rand_word(), rand_word());
    send_event(ACT_ARRIVE, rand_word(), rand_word());
    send_event(ACT_FINISHED, rand_word(), rand_word());
  endtask

  // fill the whole waiting store, drop on full, then dispatch from the full store
  task automatic test_queue_full();
    wait_drained();
    set_config(POOL_CAP, 0, 0, REG_MAX);
    send_event(ACT_CONSOLIDATE, rand_word(), rand_word());
    while (pm_wait_count < QUEUE_CAP) send_event(ACT_ARRIVE, rand_word(), rand_word());
    send_event(ACT_ARRIVE, rand_word(), rand_word());
    repeat (2) send_event(ACT_CREATED, rand_word(), rand_word());
  endtask

  // a kill sweep, a full create sweep with the pool limit over the cap, a pool of one
  task automatic test_pool_extremes();
    wait_drained();
    set_config(REG_MAX, 0, POOL_CAP, REG_MAX);
    while (pm_busy > 0) send_event(ACT_FINISHED, rand_word(), rand_word());
    repeat (2) send_event(ACT_FINISHED, rand_word(), rand_word());
    wait_drained();
    set_config(REG_MAX, 0, 0, REG_MAX);
    send_event(ACT_CONSOLIDATE, rand_word(), rand_word());
    wait_drained();
    set_config(REG_MAX, POOL_CAP, POOL_CAP, REG_MAX);
    send_event(ACT_CONSOLIDATE, rand_word(), rand_word());
    wait_drained();
    set_config(1, POOL_CAP, 0, REG_MAX);
    send_event(ACT_CREATED, rand_word(), rand_word());
    send_event(ACT_CONSOLIDATE, rand_word(), rand_word());
  endtask

  // random settings per phase; events mostly consistent with the pool state
  task automatic test_random_phases();
    int   r;
    act_t a;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      set_config(pick_setting(1, POOL_CAP), pick_setting(0, POOL_CAP),
                 pick_setting(0, POOL_CAP), pick_setting(0, REG_MAX));
      for (int i = 0; i < PHASE_EVENTS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 40) a = ACT_ARRIVE;
        else if (r < 65) a = ACT_CREATED;
        else if (r < 90) a = ACT_FINISHED;
        else a = ACT_CONSOLIDATE;
        // one in eight inconsistent events goes through unchanged
        if ($urandom_range(0, 7) != 0) begin
          if (a == ACT_CREATED && pm_pending == 0) a = ACT_CONSOLIDATE;
          if (a == ACT_FINISHED && pm_busy == 0) a = ACT_ARRIVE;
        end
        send_event(a, rand_word(), rand_word());
      end
    end
  endtask

  // ---------------- run ----------------

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire || cfg_we || !rst_n) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_behavior();
    test_underflow();
    test_queue_limit();
    test_pool_extremes();
    test_random_phases();
    test_queue_full();
    wait_drained();
    $display("Ran %0d events giving %0d results: %0d dispatch, %0d create, %0d kill, %0d drop",
             n_events, n_results, n_dispatch, n_create, n_kill, n_drop);
    $display("%0d results carried underflow; settings swept from reset through both extremes",
             n_under);
    if (err_count == 0 && owed_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
